/* hdl/efc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_pkg
// Types, register indexes and channel arithmetic shared by the 3x3 edge
// filter and its testbench.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int CHAN_W = 8;
  localparam int PIX_W = 3 * CHAN_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int IMG_WIDTH_W = 11;
  localparam int IMG_HEIGHT_W = 16;
  localparam int MIN_DIM = 3;

  typedef logic [CHAN_W-1:0] channel_t;
  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

  localparam logic [CHAN_W+2:0] CHAN_MAX = 11'sd255;

  // upper row sum minus lower row sum, clamped to one channel
  function automatic channel_t prewitt_chan(input channel_t a, input channel_t b,
                                            input channel_t c, input channel_t d,
                                            input channel_t e, input channel_t f);
    logic [CHAN_W+1:0] top;
    logic [CHAN_W+1:0] bot;
    logic signed [CHAN_W+2:0] diff;
    top = {2'b00, a} + {2'b00, b} + {2'b00, c};
    bot = {2'b00, d} + {2'b00, e} + {2'b00, f};
    diff = $signed({1'b0, top}) - $signed({1'b0, bot});
    if (diff < 0) begin
      prewitt_chan = '0;
    end else if (diff > $signed(CHAN_MAX)) begin
      prewitt_chan = '1;
    end else begin
      prewitt_chan = diff[CHAN_W-1:0];
    end
  endfunction

  function automatic pixel_t prewitt_pix(input pixel_t a, input pixel_t b, input pixel_t c,
                                         input pixel_t d, input pixel_t e, input pixel_t f);
    pixel_t res;
    for (int k = 0; k < 3; k++) begin
      res[k*CHAN_W +: CHAN_W] = prewitt_chan(a[k*CHAN_W +: CHAN_W], b[k*CHAN_W +: CHAN_W],
                                             c[k*CHAN_W +: CHAN_W], d[k*CHAN_W +: CHAN_W],
                                             e[k*CHAN_W +: CHAN_W], f[k*CHAN_W +: CHAN_W]);
    end
    return res;
  endfunction

endpackage

/* hdl/efc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module efc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/edge_filter_3x3_clamped.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_filter_3x3_clamped
// Streaming 3x3 horizontal-edge filter on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock while pixel_stall is low;
// each pixel is processed in the cycle it is taken, and its result lands
// in an output register at the following edge. Pixels leave width+1 pixel
// transactions after they enter; flush transactions after the last pixel of a
// frame push the held pixels out, one per flush. Both line stores share one
// RAM with one write and one registered read port; the read for the next
// column is issued ahead from ic_next, so the single RAM read per cycle sets the
// one-pixel-per-clock figure. A two-entry output queue lets input continue
// while a result waits; pixel_stall rises only when both entries are full.
// Interior pixels get, per channel, row above minus row below, clamped to
// 0..255; pixels on the frame border pass unchanged.
// ----------------------------------------------------------------------------
module edge_filter_3x3_clamped
  import efc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic                   kind,
  input  logic [CHAN_W-1:0]      red_in,
  input  logic [CHAN_W-1:0]      green_in,
  input  logic [CHAN_W-1:0]      blue_in,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [CHAN_W-1:0]      red_out,
  output logic [CHAN_W-1:0]      green_out,
  output logic [CHAN_W-1:0]      blue_out,
  output logic                   frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 2);
  localparam int CMP_W = (WID_W > IMG_WIDTH_W) ? WID_W : IMG_WIDTH_W;
  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MIN_W_C = CMP_W'(MIN_DIM);
  localparam logic [IMG_HEIGHT_W-1:0] MIN_H_C = IMG_HEIGHT_W'(MIN_DIM);

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;

  pixel_t                  win [9];
  logic [COL_W-1:0]        in_column;
  logic [IMG_HEIGHT_W-1:0] in_line;
  logic [COL_W-1:0]        out_column;
  logic [IMG_HEIGHT_W-1:0] out_line;
  logic [WID_W-1:0]        fill_count;

  logic                    bypass_hit;
  line_pair_t              bypass_data;
  line_pair_t              ram_rd;
  line_pair_t              line_rd;

  pixel_t                  head_pix;
  logic                    head_end;
  logic                    skid_valid;
  pixel_t                  skid_pix;
  logic                    skid_end;

  logic [CMP_W-1:0]        width_ext;
  logic [WID_W-1:0]        w_eff;
  logic [IMG_HEIGHT_W-1:0] h_eff;
  logic [WID_W-1:0]        w_plus1;
  logic [COL_W-1:0]        ic;
  logic [IMG_HEIGHT_W-1:0] il;
  logic [COL_W-1:0]        oc;
  logic [IMG_HEIGHT_W-1:0] ol;
  logic [WID_W-1:0]        fc;
  logic                    accept;
  logic                    flush;
  logic                    step;
  logic                    emit;
  logic                    drained;
  pixel_t                  px;
  pixel_t                  win_next [9];
  pixel_t                  res_pix;
  logic                    res_end;
  logic                    border;
  logic [COL_W-1:0]        ic_next;
  logic [IMG_HEIGHT_W-1:0] il_next;
  logic [COL_W-1:0]        oc_next;
  logic [IMG_HEIGHT_W-1:0] ol_next;
  logic [WID_W-1:0]        fc_next;
  logic [COL_W-1:0]        rd_addr;
  logic                    take;

  // effective frame size
  always_comb begin
    width_ext = CMP_W'(image_width);
    if (width_ext < MIN_W_C) begin
      w_eff = WID_W'(MIN_W_C);
    end else if (width_ext > MAX_W_C) begin
      w_eff = WID_W'(MAX_W_C);
    end else begin
      w_eff = WID_W'(width_ext);
    end
    h_eff = (image_height < MIN_H_C) ? MIN_H_C : image_height;
    w_plus1 = w_eff + WID_W'(1);
  end

  // position counters restart when beyond the current bounds; the fill count is clamped to width plus one
  always_comb begin
    ic = (WID_W'(in_column) >= w_eff) ? '0 : in_column;
    il = (in_line >= h_eff) ? '0 : in_line;
    oc = (WID_W'(out_column) >= w_eff) ? '0 : out_column;
    ol = (out_line >= h_eff) ? '0 : out_line;
    fc = (fill_count > w_plus1) ? w_plus1 : fill_count;
  end

  assign pixel_stall = skid_valid;
  assign accept = pixel_valid && !pixel_stall;
  assign flush = (kind == KIND_FLUSH);
  assign step = accept && !(flush && fc == '0);
  assign emit = flush || (fc == w_plus1);
  assign drained = flush && (fc == WID_W'(1));
  assign px = flush ? '0 : {red_in, green_in, blue_in};
  assign line_rd = bypass_hit ? bypass_data : ram_rd;

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = line_rd.upper;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = line_rd.middle;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = px;
  end

  always_comb begin
    border = (WID_W'(oc) == w_eff - WID_W'(1)) || (oc == '0) || (ol == '0)
             || (ol == h_eff - IMG_HEIGHT_W'(1));
    res_pix = border ? win[5]
                     : prewitt_pix(win_next[0], win_next[1], win_next[2],
                                   win_next[6], win_next[7], win_next[8]);
    res_end = (ol == h_eff - IMG_HEIGHT_W'(1)) && (WID_W'(oc) == w_eff - WID_W'(1));
  end

  always_comb begin
    ic_next = ic;
    il_next = il;
    oc_next = oc;
    ol_next = ol;
    fc_next = fc;
    if (step) begin
      if (WID_W'(ic) + WID_W'(1) >= w_eff) begin
        ic_next = '0;
        il_next = (il + IMG_HEIGHT_W'(1) >= h_eff) ? '0 : il + IMG_HEIGHT_W'(1);
      end else begin
        ic_next = ic + COL_W'(1);
      end
      if (emit) begin
        if (WID_W'(oc) + WID_W'(1) >= w_eff) begin
          oc_next = '0;
          ol_next = (ol + IMG_HEIGHT_W'(1) >= h_eff) ? '0 : ol + IMG_HEIGHT_W'(1);
        end else begin
          oc_next = oc + COL_W'(1);
        end
      end
      if (flush) begin
        fc_next = fc - WID_W'(1);
      end else if (!emit) begin
        fc_next = fc + WID_W'(1);
      end
      if (drained) begin
        ic_next = '0;
        il_next = '0;
        oc_next = '0;
        ol_next = '0;
      end
    end
  end

  // prefetch the column the next pixel will read
  assign rd_addr = ic_next;

  efc_ram #(
    .WIDTH($bits(line_pair_t)),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk    (clk),
    .wr_en  (step),
    .wr_addr(ic),
    .wr_data({line_rd.middle, px}),
    .rd_addr(rd_addr),
    .rd_data(ram_rd)
  );

  always_ff @(posedge clk) begin
    bypass_data <= {line_rd.middle, px};
    if (rst) begin
      bypass_hit <= 1'b0;
    end else begin
      bypass_hit <= step && (rd_addr == ic);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[IMG_WIDTH_W-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[IMG_HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
      in_column <= '0;
      in_line <= '0;
      out_column <= '0;
      out_line <= '0;
      fill_count <= '0;
    end else if (step) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= win_next[k];
      end
      in_column <= ic_next;
      in_line <= il_next;
      out_column <= oc_next;
      out_line <= ol_next;
      fill_count <= fc_next;
    end
  end

  // two-entry output queue: head register plus skid
  assign take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        head_pix <= skid_pix;
        head_end <= skid_end;
        skid_valid <= 1'b0;
      end
    end else if (step && emit) begin
      if (!result_valid || take) begin
        head_pix <= res_pix;
        head_end <= res_end;
        result_valid <= 1'b1;
      end else begin
        skid_pix <= res_pix;
        skid_end <= res_end;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  assign red_out = head_pix[2*CHAN_W +: CHAN_W];
  assign green_out = head_pix[CHAN_W +: CHAN_W];
  assign blue_out = head_pix[0 +: CHAN_W];
  assign frame_end = head_end;

  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held while head register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid filled while head was free");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (step && emit && res_end) |=> (out_column == '0 && out_line == '0))
    else $error("output position did not wrap after last pixel of frame");

  a_drain_resets: assert property (@(posedge clk) disable iff (rst)
    (step && drained) |=> (fill_count == '0 && in_column == '0 && in_line == '0))
    else $error("counters not cleared after final flush");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    step |=> (fill_count <= $past(w_plus1)))
    else $error("fill count above width plus one");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 clamped edge filter.
// A queue-fed driver offers pixel and flush transactions with random gaps;
// a clocked predictor tracks line stores, window and position counters and
// queues the expected output pixels; a monitor compares every accepted result
// field by field. Runs cover out-of-range register values, tiny frames,
// back-to-back frames, partial flushes, two frame heights at one width and
// long output back-pressure.
// ----------------------------------------------------------------------------
module testbench
  import efc_pkg::*;
();

  localparam int MAX_W = 1024;
  localparam int RESET_WIDTH = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int TIMEOUT_NS = 8000000;

  typedef struct packed {
    logic     kind;
    channel_t red;
    channel_t green;
    channel_t blue;
  } pixel_item_t;

  typedef struct packed {
    channel_t red;
    channel_t green;
    channel_t blue;
    logic     frame_end;
  } pixel_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  logic                   kind = KIND_PIXEL;
  channel_t               red_in = '0;
  channel_t               green_in = '0;
  channel_t               blue_in = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  channel_t               red_out;
  channel_t               green_out;
  channel_t               blue_out;
  logic                   frame_end;

  edge_filter_3x3_clamped #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .kind(kind),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .frame_end(frame_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state as seen by the predictor
  logic [IMG_WIDTH_W-1:0]  width_reg = IMG_WIDTH_W'(RESET_WIDTH);
  logic [IMG_HEIGHT_W-1:0] height_reg = IMG_HEIGHT_W'(RESET_HEIGHT);
  pixel_t                  upper_store [MAX_W];
  pixel_t                  middle_store [MAX_W];
  pixel_t                  win [9];
  int unsigned             col_in = 0;
  int unsigned             row_in = 0;
  int unsigned             col_out = 0;
  int unsigned             row_out = 0;
  int unsigned             held = 0;

  pixel_item_t             pending_items [$];
  pixel_result_t           expected_pixels [$];

  // stimulus planning
  int unsigned             plan_w = RESET_WIDTH;
  int unsigned             plan_h = RESET_HEIGHT;
  int unsigned             plan_fill = 0;
  int unsigned             queued_items = 0;
  int unsigned             formats_run = 0;

  bit                      idle_mode = 1'b1;
  bit                      long_hold_req = 1'b0;
  int unsigned             long_hold_left = 0;
  int unsigned             send_gap = 0;
  int unsigned             stall_left = 0;
  logic                    item_taken = 1'b0;
  pixel_item_t             offered;
  pixel_result_t           want;

  int unsigned             items_accepted = 0;
  int unsigned             results_seen = 0;
  int unsigned             frame_ends = 0;
  int unsigned             errors = 0;

  function automatic int unsigned eff_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < MIN_DIM) return MIN_DIM;
    return height_reg;
  endfunction

  function automatic pixel_t vertical_gradient();
    pixel_t res;
    int     diff;
    int     k;
    for (k = 0; k < 3; k++) begin
      diff = int'(win[0][k*CHAN_W +: CHAN_W]) + int'(win[1][k*CHAN_W +: CHAN_W])
           + int'(win[2][k*CHAN_W +: CHAN_W]) - int'(win[6][k*CHAN_W +: CHAN_W])
           - int'(win[7][k*CHAN_W +: CHAN_W]) - int'(win[8][k*CHAN_W +: CHAN_W]);
      if (diff < 0) begin
        diff = 0;
      end else if (diff > 255) begin
        diff = 255;
      end
      res[k*CHAN_W +: CHAN_W] = diff[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic void filter_step(input logic item_kind, input pixel_t px_in);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int            k;
    pixel_t        px;
    pixel_t        edge_px;
    pixel_t        res;
    pixel_result_t r;
    w = eff_width();
    h = eff_height();
    if (col_in >= w) col_in = 0;
    if (row_in >= h) row_in = 0;
    if (col_out >= w) col_out = 0;
    if (row_out >= h) row_out = 0;
    if (held > w + 1) held = w + 1;
    if (item_kind == KIND_FLUSH && held == 0) return;

    px = (item_kind == KIND_FLUSH) ? '0 : px_in;
    edge_px = win[5];
    c = col_in;
    for (k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = upper_store[c];
    win[5] = middle_store[c];
    win[8] = px;
    upper_store[c] = middle_store[c];
    middle_store[c] = px;

    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
      if (row_in >= h) row_in = 0;
    end

    if (item_kind == KIND_PIXEL && held < w + 1) begin
      held++;
      return;
    end

    if (col_out == w - 1) begin
      res = edge_px;
    end else if (col_out == 0 || row_out == 0 || row_out == h - 1) begin
      res = win[4];
    end else begin
      res = vertical_gradient();
    end
    r.red = res[3*CHAN_W-1:2*CHAN_W];
    r.green = res[2*CHAN_W-1:CHAN_W];
    r.blue = res[CHAN_W-1:0];
    r.frame_end = (row_out == h - 1 && col_out == w - 1);
    expected_pixels.push_back(r);

    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
      if (row_out >= h) row_out = 0;
    end

    if (item_kind == KIND_FLUSH) begin
      held--;
      if (held == 0) begin
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  function automatic channel_t rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return channel_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_pixel(input channel_t r, input channel_t g, input channel_t b);
    pending_items.push_back(pixel_item_t'{KIND_PIXEL, r, g, b});
    queued_items++;
    if (plan_fill < plan_w + 1) plan_fill++;
  endfunction

  // flush payload is don't-care, so randomize it
  function automatic void queue_flush();
    pending_items.push_back(pixel_item_t'{KIND_FLUSH, rand_chan(), rand_chan(), rand_chan()});
    if (plan_fill > 0) begin
      plan_fill--;
      queued_items++;
    end
  endfunction

  function automatic void queue_random_pixels(input int unsigned count);
    repeat (count) queue_pixel(rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic void drain_all();
    repeat (plan_fill) queue_flush();
    repeat ($urandom_range(0, 2)) queue_flush();
  endfunction

  function automatic void check_field(input string field, input logic [CHAN_W-1:0] exp_v,
                                      input logic [CHAN_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
      errors++;
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || pixel_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val[IMG_WIDTH_W-1:0];
    end else begin
      height_reg = val[IMG_HEIGHT_W-1:0];
    end
    plan_w = eff_width();
    plan_h = eff_height();
    if (plan_fill > plan_w + 1) plan_fill = plan_w + 1;
    formats_run++;
    @(posedge clk);
  endtask

  task automatic pick_random_format();
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;
    int unsigned           which;
    case ($urandom_range(0, 9))
      0: wv = 16'd0;
      1: wv = 16'd2;
      2: wv = 16'hF805;
      3: wv = 16'd16;
      default: wv = CFG_DATA_W'($urandom_range(3, 8));
    endcase
    case ($urandom_range(0, 9))
      0: hv = 16'd1;
      1: hv = 16'hFFFF;
      2: hv = 16'd2;
      default: hv = CFG_DATA_W'($urandom_range(3, 6));
    endcase
    which = $urandom_range(0, 2);
    wait_drained();
    if (which != 1) write_reg(CFG_IMAGE_WIDTH, wv);
    if (which != 0) write_reg(CFG_IMAGE_HEIGHT, hv);
  endtask

  // whole lines back to back (whole frames for heights up to 8), sometimes a ragged tail or a partial flush
  task automatic build_random_run();
    int unsigned lines;
    int unsigned n_px;
    int unsigned cut;
    lines = (plan_h > 8) ? $urandom_range(2, 5) : plan_h;
    n_px = plan_w * lines * $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) n_px += $urandom_range(1, 2 * plan_w);
    if (n_px < plan_w + 1) n_px = plan_w + 1;
    queue_random_pixels(n_px);
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, plan_w);
      repeat (cut) queue_flush();
      queue_random_pixels(cut + $urandom_range(0, plan_w));
    end
    if ($urandom_range(0, 2) != 0) drain_all();
  endtask

  // accept and predict
  always @(posedge clk) begin
    item_taken = !rst && pixel_valid && !pixel_stall;
    if (item_taken) begin
      filter_step(kind, {red_in, green_in, blue_in});
      items_accepted++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || item_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        pixel_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        offered = pending_items.pop_front();
        kind <= offered.kind;
        red_in <= offered.red;
        green_in <= offered.green;
        blue_in <= offered.blue;
        pixel_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      long_hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      result_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got r=%h g=%h b=%h end=%b",
                 $time, red_out, green_out, blue_out, frame_end);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", want.red, red_out);
        check_field("green_out", want.green, green_out);
        check_field("blue_out", want.blue, blue_out);
        check_field("frame_end", CHAN_W'(want.frame_end), CHAN_W'(frame_end));
        if (frame_end === 1'b1) frame_ends++;
      end
      results_seen++;
    end
  end

  initial begin
    int unsigned k;
    int unsigned random_base;
    for (k = 0; k < MAX_W; k++) begin
      upper_store[k] = '0;
      middle_store[k] = '0;
    end
    for (k = 0; k < 9; k++) win[k] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out-of-range registers give a 3x3 frame; two frames with opposite gradients
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    queue_flush();
    repeat (3) queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h01, 8'h80, 8'hFE);
    queue_pixel(8'h7F, 8'h00, 8'hFF);
    queue_pixel(8'h55, 8'hAA, 8'h33);
    repeat (3) queue_pixel(8'h00, 8'h00, 8'h00);
    repeat (3) queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'h00, 8'h80);
    queue_pixel(8'h10, 8'hEF, 8'h01);
    queue_pixel(8'hC3, 8'h3C, 8'h99);
    repeat (3) queue_pixel(8'hFF, 8'hFF, 8'hFF);
    drain_all();
    wait_drained();

    // hold the output long enough to back up the input
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    idle_mode = 1'b0;
    k = results_seen;
    queue_random_pixels(100);
    while (results_seen < k + 10) @(posedge clk);
    long_hold_req = 1'b1;
    drain_all();
    wait_drained();

    random_base = queued_items;
    while (queued_items - random_base < RANDOM_ITEMS) begin
      while (pending_items.size() != 0) @(posedge clk);
      if (plan_fill == 0 && $urandom_range(0, 2) != 0) pick_random_format();
      idle_mode = ($urandom_range(0, 3) != 0);
      build_random_run();
    end
    idle_mode = 1'b1;
    drain_all();
    wait_drained();

    // two frame heights at one width, drained in between
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    write_reg(CFG_IMAGE_HEIGHT, 16'd7);
    queue_random_pixels(22);
    drain_all();
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    queue_random_pixels(30);
    drain_all();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Run covered %0d input transactions, %0d results checked, %0d frame ends.",
             items_accepted, results_seen, frame_ends);
    $display("Small frames over %0d register writes, partial flushes, gaps and back-pressure.",
             formats_run);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("** edge_filter_3x3_clamped: PASSED **");
    end else begin
      $display("** edge_filter_3x3_clamped: FAILED **");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("%0t: timeout with %0d results outstanding", $time, expected_pixels.size());
    $display("** edge_filter_3x3_clamped: FAILED **");
    $finish;
  end

endmodule
